// ----- rtl/core/mfps_pkg.sv -----
// shared constants and modular arithmetic for the modular fenwick prefix-sum block
`default_nettype none

package mfps_pkg;

    // field widths fixed by the item format
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 30;

    // default tree depth
    localparam int TREE_SIZE_DEF = 1024;

    // prime modulus, fits in the value width
    localparam logic [VALUE_W-1:0] PRIME_MOD = VALUE_W'(1000000007);

    // function codes of an input request
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // sum of two residues with one conditional subtract of the prime
    function automatic logic [VALUE_W-1:0] mod_add(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] s;
        logic [VALUE_W:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - {1'b0, PRIME_MOD};
        if (s >= {1'b0, PRIME_MOD}) begin
            return t[VALUE_W-1:0];
        end
        return s[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mfps_front.sv -----
// front end: classifies incoming requests and holds them in a short queue
`default_nettype none

module mfps_front #(
    parameter int TREE_SIZE = mfps_pkg::TREE_SIZE_DEF,
    parameter int AW        = $clog2(TREE_SIZE)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_func,
    input  wire logic [mfps_pkg::INDEX_W-1:0] i_index,
    input  wire logic [mfps_pkg::VALUE_W-1:0] i_value,
    // back end side
    input  wire logic                         i_clearing,
    input  wire logic                         i_pop,
    output logic                              o_head_valid,
    output logic                              o_head_query,
    output logic [AW-1:0]                     o_head_pos,
    output logic [mfps_pkg::VALUE_W-1:0]      o_head_value
);

    localparam int QD = 2;
    localparam int PTR_W = $clog2(QD);
    localparam int CNT_W = $clog2(QD + 1);

    logic [31:0]                    idx_ext;
    logic                           in_range;
    logic                           drop;
    logic                           push;
    logic                           full;
    logic [AW-1:0]                  start_pos;
    logic [mfps_pkg::VALUE_W-1:0]   value_red;

    logic                           r_q_query [QD];
    logic [AW-1:0]                  r_q_pos   [QD];
    logic [mfps_pkg::VALUE_W-1:0]   r_q_value [QD];
    logic [PTR_W-1:0]               r_wr_ptr;
    logic [PTR_W-1:0]               r_rd_ptr;
    logic [CNT_W-1:0]               r_count;

    // classify: range check, query saturation, dropped adds, value reduction
    always_comb begin
        idx_ext   = 32'(i_index);
        in_range  = idx_ext < 32'(TREE_SIZE);
        start_pos = in_range ? AW'(idx_ext) : AW'(TREE_SIZE - 1);
        drop      = (i_func == mfps_pkg::FUNC_ADD) && ((i_index == '0) || !in_range);
        value_red = mfps_pkg::mod_add(i_value, '0);
    end

    // queue handshake
    assign full         = r_count == CNT_W'(QD);
    assign o_stall      = full || i_clearing;
    assign push         = i_valid && !o_stall && !drop;
    assign o_head_valid = r_count != '0;
    assign o_head_query = r_q_query[r_rd_ptr];
    assign o_head_pos   = r_q_pos[r_rd_ptr];
    assign o_head_value = r_q_value[r_rd_ptr];

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_query[r_wr_ptr] <= i_func == mfps_pkg::FUNC_QUERY;
            r_q_pos[r_wr_ptr]   <= start_pos;
            r_q_value[r_wr_ptr] <= value_red;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mfps_back.sv -----
// back end: tree store, clearing sweep, upward and downward walks, result register
`default_nettype none

module mfps_back #(
    parameter int TREE_SIZE = mfps_pkg::TREE_SIZE_DEF,
    parameter int AW        = $clog2(TREE_SIZE)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // queue side
    input  wire logic                         i_head_valid,
    input  wire logic                         i_head_query,
    input  wire logic [AW-1:0]                i_head_pos,
    input  wire logic [mfps_pkg::VALUE_W-1:0] i_head_value,
    output logic                              o_pop,
    output logic                              o_clearing,
    // result channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [mfps_pkg::VALUE_W-1:0]      o_prefix_sum
);

    localparam int PW = AW + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WORK,
        S_RESULT
    } t_state;

    t_state                         r_state;
    logic [AW-1:0]                  r_clr_addr;
    logic                           r_is_query;
    logic [PW-1:0]                  r_pos;
    logic [mfps_pkg::VALUE_W-1:0]   r_val;
    logic [mfps_pkg::VALUE_W-1:0]   r_acc;
    logic                           r_out_valid;
    logic [mfps_pkg::VALUE_W-1:0]   r_out_sum;

    logic [mfps_pkg::VALUE_W-1:0]   r_mem [TREE_SIZE];
    logic [mfps_pkg::VALUE_W-1:0]   r_rd_data;

    logic [PW-1:0]                  lowbit;
    logic [PW-1:0]                  pos_up;
    logic [PW-1:0]                  pos_dn;
    logic                           up_more;
    logic                           dn_more;
    logic [mfps_pkg::VALUE_W-1:0]   operand;
    logic [mfps_pkg::VALUE_W-1:0]   step_sum;
    logic                           out_free;
    logic                           we;
    logic [AW-1:0]                  waddr;
    logic [mfps_pkg::VALUE_W-1:0]   wdata;
    logic                           re;
    logic [AW-1:0]                  raddr;

    // walk arithmetic: lowest set bit, next position, entry update
    always_comb begin
        lowbit   = r_pos & (~r_pos + PW'(1));
        pos_up   = r_pos + lowbit;
        pos_dn   = r_pos - lowbit;
        up_more  = pos_up < PW'(TREE_SIZE);
        dn_more  = pos_dn != '0;
        operand  = r_is_query ? r_acc : r_val;
        step_sum = mfps_pkg::mod_add(r_rd_data, operand);
    end

    assign out_free     = !r_out_valid || !i_stall;
    assign o_pop        = (r_state == S_IDLE) && i_head_valid;
    assign o_clearing   = r_state == S_CLEAR;
    assign o_valid      = r_out_valid;
    assign o_prefix_sum = r_out_sum;

    // store port control
    always_comb begin
        we    = 1'b0;
        waddr = r_pos[AW-1:0];
        wdata = step_sum;
        re    = 1'b0;
        raddr = i_head_pos;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_addr;
                wdata = '0;
            end
            S_IDLE: begin
                re    = i_head_valid && (i_head_pos != '0);
                raddr = i_head_pos;
            end
            S_WORK: begin
                we    = !r_is_query;
                re    = r_is_query ? dn_more : up_more;
                raddr = r_is_query ? pos_dn[AW-1:0] : pos_up[AW-1:0];
            end
            S_RESULT: begin
                we = 1'b0;
                re = 1'b0;
            end
            default: begin
                we = 1'b0;
                re = 1'b0;
            end
        endcase
    end

    // tree store, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result valid: set on a finished query, cleared once taken
            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(TREE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_is_query <= i_head_query;
                        r_pos      <= {1'b0, i_head_pos};
                        r_val      <= i_head_value;
                        r_acc      <= '0;
                        r_state    <= (i_head_pos == '0) ? S_RESULT : S_WORK;
                    end
                end
                S_WORK: begin
                    if (r_is_query) begin
                        r_acc <= step_sum;
                        if (dn_more) begin
                            r_pos <= pos_dn;
                        end else begin
                            r_state <= S_RESULT;
                        end
                    end else begin
                        if (up_more) begin
                            r_pos <= pos_up;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out_sum <= r_acc;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/modular_fenwick_prefix_sum.sv -----
// top level of the modular fenwick prefix-sum block
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_stall  i_func, i_index, i_value
//  result    out        o_valid / i_stall  o_prefix_sum
//
// a request enters the queue; the back end then issues the first store read and
// visits one tree entry after another (at most log2(TREE_SIZE) of them), and a
// query then loads the result register. the back end takes a new request only
// when it is idle again, so requests are handled one at a time.
// after reset a sweep clears every store entry with o_stall high.
// the two-entry queue takes requests while the back end walks or a result waits.
`default_nettype none

module modular_fenwick_prefix_sum #(
    parameter int TREE_SIZE = mfps_pkg::TREE_SIZE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_func,
    input  wire logic [mfps_pkg::INDEX_W-1:0] i_index,
    input  wire logic [mfps_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [mfps_pkg::VALUE_W-1:0]      o_prefix_sum
);

    localparam int AW = $clog2(TREE_SIZE);

    logic                           head_valid;
    logic                           head_query;
    logic [AW-1:0]                  head_pos;
    logic [mfps_pkg::VALUE_W-1:0]   head_value;
    logic                           pop;
    logic                           clearing;

    // request classification and queue
    mfps_front #(
        .TREE_SIZE (TREE_SIZE),
        .AW        (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_clearing   (clearing),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_query (head_query),
        .o_head_pos   (head_pos),
        .o_head_value (head_value)
    );

    // tree walks over the store
    mfps_back #(
        .TREE_SIZE (TREE_SIZE),
        .AW        (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_query (head_query),
        .i_head_pos   (head_pos),
        .i_head_value (head_value),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_prefix_sum (o_prefix_sum)
    );

endmodule

`default_nettype wire

// ----- bench/modular_fenwick_prefix_sum_tb.sv -----
// testbench for the modular fenwick prefix-sum block: directed table, then random requests
module modular_fenwick_prefix_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_DEPTH     = mfps_pkg::TREE_SIZE_DEF;
    localparam int DIRECTED_COUNT = 18;
    localparam int RANDOM_COUNT   = 1032;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 40;
    localparam logic [mfps_pkg::VALUE_W-1:0] VALUE_ALL_ONES = '1;

    // one row of the directed table; sum is used only where known is set
    typedef struct packed {
        logic                         func;
        logic [mfps_pkg::INDEX_W-1:0] index;
        logic [mfps_pkg::VALUE_W-1:0] value;
        logic                         known;
        logic [mfps_pkg::VALUE_W-1:0] sum;
    } t_directed_row;

    // a prefix sum still owed by the block
    typedef struct {
        logic [mfps_pkg::INDEX_W-1:0] index;
        logic [mfps_pkg::VALUE_W-1:0] sum;
    } t_owed_sum;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         i_func  = mfps_pkg::FUNC_ADD;
    logic [mfps_pkg::INDEX_W-1:0] i_index = '0;
    logic [mfps_pkg::VALUE_W-1:0] i_value = '0;
    logic                         i_stall = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic [mfps_pkg::VALUE_W-1:0] o_prefix_sum;

    // predicted tree contents and sums awaiting their result
    logic [mfps_pkg::VALUE_W-1:0] fen_entries [TREE_DEPTH];
    t_owed_sum                    owed_sums [$];
    t_directed_row                directed_rows [DIRECTED_COUNT];
    int                           error_count = 0;
    bit                           calm        = 1'b0;
    bit                           hold_req    = 1'b0;

    modular_fenwick_prefix_sum dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_prefix_sum (o_prefix_sum)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("modular_fenwick_prefix_sum verification failed");
        $finish;
    end

    // sum of two residues modulo the prime
    function automatic logic [mfps_pkg::VALUE_W-1:0] residue_sum(
        input logic [mfps_pkg::VALUE_W-1:0] a,
        input logic [mfps_pkg::VALUE_W-1:0] b);
        longint total;
        total = longint'(a) + longint'(b);
        return mfps_pkg::VALUE_W'(total % longint'(mfps_pkg::PRIME_MOD));
    endfunction

    // upward walk: add a residue at one position
    task automatic fen_add(input int pos, input logic [mfps_pkg::VALUE_W-1:0] residue);
        int k;
        k = pos;
        while (k > 0 && k < TREE_DEPTH) begin
            fen_entries[k] = residue_sum(fen_entries[k], residue);
            k = k + (k & -k);
        end
    endtask

    // downward walk: prefix sum of positions 1..pos, pos saturating at the top entry
    function automatic logic [mfps_pkg::VALUE_W-1:0] fen_prefix(input int pos);
        int                           k;
        logic [mfps_pkg::VALUE_W-1:0] acc;
        k   = (pos > TREE_DEPTH - 1) ? TREE_DEPTH - 1 : pos;
        acc = '0;
        while (k > 0) begin
            acc = residue_sum(acc, fen_entries[k]);
            k   = k - (k & -k);
        end
        return acc;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // offer one request, wait for the handshake, then advance the prediction
    task automatic offer_request(input logic f, input logic [mfps_pkg::INDEX_W-1:0] idx,
                                 input logic [mfps_pkg::VALUE_W-1:0] val,
                                 input logic known,
                                 input logic [mfps_pkg::VALUE_W-1:0] typed_sum);
        int                           gap;
        logic [mfps_pkg::VALUE_W-1:0] residue;
        t_owed_sum                    due;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        // request taken at this edge
        residue = (val >= mfps_pkg::PRIME_MOD) ? val - mfps_pkg::PRIME_MOD : val;
        if (f == mfps_pkg::FUNC_ADD) begin
            fen_add(int'(idx), residue);
        end else begin
            due.index = idx;
            due.sum   = known ? typed_sum : fen_prefix(int'(idx));
            owed_sums.push_back(due);
        end
    endtask

    // result side: random stalls, one long hold on request, field check
    initial begin : result_sink
        int        pause;
        t_owed_sum due;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                pause    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                pause = calm ? 0 : $urandom_range(0, 5);
            end
            if (pause > 0) begin
                i_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (owed_sums.size() == 0) begin
                report_mismatch($sformatf("prefix sum %0d with no query waiting",
                                          o_prefix_sum));
            end else begin
                due = owed_sums.pop_front();
                if (o_prefix_sum !== due.sum) begin
                    report_mismatch($sformatf("query index %0d: prefix sum %0d, want %0d",
                                              due.index, o_prefix_sum, due.sum));
                end
            end
        end
    end

    // request side: reset, directed table, random requests, drain
    initial begin : request_source
        logic                         f;
        logic [mfps_pkg::INDEX_W-1:0] idx;
        logic [mfps_pkg::VALUE_W-1:0] val;
        int                           drain;
        for (int e = 0; e < TREE_DEPTH; e++) begin
            fen_entries[e] = '0;
        end

        // fresh tree, index zero, values above the prime, wrap of the modulus
        directed_rows[0]  = '{mfps_pkg::FUNC_QUERY, 10'd1023, 30'd0, 1'b1, 30'd0};
        directed_rows[1]  = '{mfps_pkg::FUNC_QUERY, 10'd0, 30'd0, 1'b1, 30'd0};
        directed_rows[2]  = '{mfps_pkg::FUNC_ADD, 10'd0, VALUE_ALL_ONES, 1'b0, 30'd0};
        directed_rows[3]  = '{mfps_pkg::FUNC_QUERY, 10'd1023, 30'd0, 1'b1, 30'd0};
        directed_rows[4]  = '{mfps_pkg::FUNC_ADD, 10'd1, VALUE_ALL_ONES, 1'b0, 30'd0};
        directed_rows[5]  = '{mfps_pkg::FUNC_QUERY, 10'd1, 30'd0, 1'b1, 30'd73741816};
        directed_rows[6]  = '{mfps_pkg::FUNC_ADD, 10'd1023, mfps_pkg::PRIME_MOD - 30'd1,
                              1'b0, 30'd0};
        directed_rows[7]  = '{mfps_pkg::FUNC_QUERY, 10'd1023, 30'd0, 1'b1, 30'd73741815};
        directed_rows[8]  = '{mfps_pkg::FUNC_QUERY, 10'd0, VALUE_ALL_ONES, 1'b1, 30'd0};
        directed_rows[9]  = '{mfps_pkg::FUNC_ADD, 10'd512, mfps_pkg::PRIME_MOD, 1'b0, 30'd0};
        directed_rows[10] = '{mfps_pkg::FUNC_QUERY, 10'd512, 30'd0, 1'b0, 30'd0};
        directed_rows[11] = '{mfps_pkg::FUNC_ADD, 10'd2, mfps_pkg::PRIME_MOD - 30'd1,
                              1'b0, 30'd0};
        directed_rows[12] = '{mfps_pkg::FUNC_QUERY, 10'd2, 30'd0, 1'b0, 30'd0};
        directed_rows[13] = '{mfps_pkg::FUNC_ADD, 10'd1023, 30'd0, 1'b0, 30'd0};
        directed_rows[14] = '{mfps_pkg::FUNC_QUERY, 10'd1023, 30'd0, 1'b0, 30'd0};
        directed_rows[15] = '{mfps_pkg::FUNC_QUERY, 10'd511, VALUE_ALL_ONES, 1'b0, 30'd0};
        directed_rows[16] = '{mfps_pkg::FUNC_ADD, 10'd768, 30'h2000_0000, 1'b0, 30'd0};
        directed_rows[17] = '{mfps_pkg::FUNC_QUERY, 10'd1000, 30'd0, 1'b0, 30'd0};

        // reset, then the block clears its store with stall high
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[r]) begin
            offer_request(directed_rows[r].func, directed_rows[r].index,
                          directed_rows[r].value, directed_rows[r].known,
                          directed_rows[r].sum);
        end

        // random adds and queries; every fourth stretch runs without idling
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            calm = ((n / 128) % 4) == 3;
            if (n == 100 || n == 640) begin
                hold_req = 1'b1;
            end
            f = $urandom_range(0, 1) ? mfps_pkg::FUNC_QUERY : mfps_pkg::FUNC_ADD;
            case ($urandom_range(0, 7))
                0: idx = '0;
                1: idx = '1;
                2: idx = mfps_pkg::INDEX_W'(1) << $urandom_range(0, mfps_pkg::INDEX_W - 1);
                default: idx = mfps_pkg::INDEX_W'($urandom_range(0, TREE_DEPTH - 1));
            endcase
            case ($urandom_range(0, 7))
                0: val = mfps_pkg::PRIME_MOD - 30'd1;
                1: val = mfps_pkg::VALUE_W'($urandom_range(mfps_pkg::PRIME_MOD,
                                                           VALUE_ALL_ONES));
                2: val = mfps_pkg::VALUE_W'($urandom_range(0, 15));
                default: val = mfps_pkg::VALUE_W'($urandom);
            endcase
            offer_request(f, idx, val, 1'b0, '0);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        // wait for the outstanding sums, then watch for strays
        drain = 0;
        while (owed_sums.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (owed_sums.size() != 0) begin
            report_mismatch($sformatf("%0d query results never arrived", owed_sums.size()));
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("modular_fenwick_prefix_sum verification clean");
        end else begin
            $display("modular_fenwick_prefix_sum verification failed");
        end
        $finish;
    end

endmodule
